/* hw/rtl/rthac_pkg.sv */
// Shared types, constants and helpers for the ray/triangle hit accumulator.
package rthac_pkg;

	localparam int WORDS_PER_TRI = 13;
	localparam int W_NRM   = 0;
	localparam int W_PNT   = 3;
	localparam int W_VTX   = 6;
	localparam int W_COLOR = 12;

	// wide enough for every value that gets clamped to 32 bits signed
	localparam int SAT_W = 96;

	localparam logic [2:0] CFG_EMIT_X    = 3'd0;
	localparam logic [2:0] CFG_EMIT_Y    = 3'd1;
	localparam logic [2:0] CFG_EMIT_Z    = 3'd2;
	localparam logic [2:0] CFG_IMG_RES   = 3'd3;
	localparam logic [2:0] CFG_DET_EXT   = 3'd4;
	localparam logic [2:0] CFG_TRI_COUNT = 3'd5;

	typedef enum logic [4:0] {
		S_IDLE, S_PDIV, S_PWAIT, S_PEND, S_GMUL, S_GDIV, S_GWAIT, S_GEND,
		S_TSTART, S_FETCH, S_FWAIT, S_DMUL, S_DACC, S_NMUL, S_NACC,
		S_QLO, S_QHI, S_QDIV, S_QWAIT, S_QEND, S_CMUL1, S_CMUL2, S_CCMP,
		S_HIT, S_NEXT, S_FIN
	} ctrl_state_t;

	typedef enum logic [4:0] {
		OP_NONE, OP_PDIV, OP_PEND, OP_GMUL, OP_GDIV, OP_GEND, OP_TSTART,
		OP_FETCH, OP_DMUL, OP_DACC, OP_NMUL, OP_NACC, OP_QLO, OP_QHI,
		OP_QDIV, OP_QEND, OP_CMUL1, OP_CMUL2, OP_CCMP, OP_HIT, OP_NEXT,
		OP_DONE
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   take_load;
		logic   take_cast;
	} dp_cmd_t;

	typedef struct packed {
		logic       pix_oor;
		logic       div_busy;
		logic       fetch_last;
		logic       dy_zero;
		logic       den_zero;
		logic       slot_done;
		logic [1:0] kcnt;
		logic       out_free;
	} dp_stat_t;

	function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
		logic hi_ones;
		logic hi_zeros;
		hi_ones  = &v[SAT_W-1:31];
		hi_zeros = ~|v[SAT_W-1:31];
		if (hi_ones || hi_zeros) begin
			return v[31:0];
		end else if (v[SAT_W-1]) begin
			return 32'sh8000_0000;
		end else begin
			return 32'sh7fff_ffff;
		end
	endfunction

endpackage

/* hw/rtl/rthac_ram.sv */
// Generic single-port-write, registered-read RAM.
module rthac_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

/* hw/rtl/rthac_div.sv */
// Iterative restoring unsigned divider, one quotient bit per cycle.
module rthac_div #(
	parameter int N = 80,
	parameter int M = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [N-1:0] dividend,
	input  logic [M-1:0] divisor,
	output logic         busy,
	output logic [N-1:0] quot,
	output logic [M-1:0] rem
);

	localparam int CW = $clog2(N + 1);

	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [N-1:0]  q_q;
	logic [M-1:0]  r_q;
	logic [M-1:0]  dv_q;
	logic [M:0]    trial;
	logic [M+1:0]  diff;
	logic          ge;

	assign trial = {r_q, q_q[N-1]};
	assign diff  = {1'b0, trial} - {2'b00, dv_q};
	assign ge    = ~diff[M+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(N);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q  <= dividend;
			r_q  <= '0;
			dv_q <= divisor;
		end else if (busy_q) begin
			r_q <= ge ? diff[M-1:0] : trial[M-1:0];
			q_q <= {q_q[N-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quot = q_q;
	assign rem  = r_q;

endmodule

/* hw/rtl/rthac_dp.sv */
// Datapath: config registers, triangle table, shared multiplier and divider.
module rthac_dp import rthac_pkg::*; #(
	parameter int MAX_TRIANGLES  = 256,
	parameter int MAX_RESOLUTION = 256,
	parameter int FRAC_BITS      = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [7:0]         tri_slot,
	input  logic [3:0]         word_select,
	input  logic signed [31:0] word_value,
	input  logic [15:0]        pixel_number,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [15:0]        pixel_out,
	output logic signed [31:0] color_sum,
	output logic [8:0]         hit_total
);

	localparam int RW    = $clog2(MAX_RESOLUTION + 1);
	localparam int CNT_W = $clog2(MAX_TRIANGLES + 1);
	localparam int DEPTH = MAX_TRIANGLES * WORDS_PER_TRI;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ACC_W = 67 - FRAC_BITS;
	localparam int NM_W  = ACC_W - 1;
	localparam int HW    = (NM_W + 1) / 2;
	localparam int DVD_W = 32 + 2 * HW;
	localparam int SUM_W = 33 + CNT_W;

	// config
	logic signed [31:0] ex_q, ey_q, ez_q;
	logic [8:0]         res_q;
	logic [14:0]        ext_q;
	logic [8:0]         tcnt_q;

	// cast state
	logic [15:0]              pix_q;
	logic [RW-1:0]            col_q, row_q;
	logic signed [31:0]       dx_q, dy_q, dz_q;
	logic [CNT_W-1:0]         slot_q;
	logic [3:0]               wcnt_q;
	logic [3:0]               rd_idx_q;
	logic                     rd_vld_q;
	logic [1:0]               kcnt_q;
	logic signed [31:0]       w_q [WORDS_PER_TRI];
	logic signed [65:0]       prod_q;
	logic signed [65:0]       cp_q;
	logic signed [ACC_W-1:0]  den_q, num_q;
	logic [DVD_W-1:0]         dvd_q;
	logic                     neg_q;
	logic signed [31:0]       px_q, py_q;
	logic                     pos_q, ng_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]         hits_q;

	logic               out_valid_q;
	logic [15:0]        pixel_out_q;
	logic signed [31:0] color_sum_q;
	logic [8:0]         hit_total_q;

	// combinational
	logic [RW-1:0]           res_eff, half;
	logic [CNT_W-1:0]        tcnt_eff;
	logic                    ram_we;
	logic [AW-1:0]           ram_waddr, ram_raddr;
	logic [31:0]             ram_rdata;
	logic signed [31:0]      n_sel, c_sel, e_sel, d_sel;
	logic signed [31:0]      vxa, vya, vxb, vyb;
	logic signed [32:0]      ex33, ey33, qx33, qy33;
	logic signed [RW:0]      g_s;
	logic signed [31:0]      w_sel;
	logic [31:0]             dmag;
	logic signed [ACC_W-1:0] num_abs, den_abs;
	logic [2*HW-1:0]         nmag;
	logic [65:0]             pmag;
	logic signed [32:0]      mul_a, mul_b;
	logic                    div_start;
	logic [DVD_W-1:0]        div_dvd;
	logic [NM_W-1:0]         div_dvs;
	logic                    div_busy;
	logic [DVD_W-1:0]        div_quot;
	logic [NM_W-1:0]         div_rem;
	logic signed [DVD_W:0]   q_s;
	logic signed [31:0]      q32;
	logic                    out_take;

	always_comb begin
		if (res_q == '0) begin
			res_eff = RW'(1);
		end else if (32'(res_q) > MAX_RESOLUTION) begin
			res_eff = RW'(MAX_RESOLUTION);
		end else begin
			res_eff = RW'(res_q);
		end
	end
	assign half     = res_eff >> 1;
	assign tcnt_eff = CNT_W'((32'(tcnt_q) > MAX_TRIANGLES) ? MAX_TRIANGLES : 32'(tcnt_q));

	// triangle table
	assign ram_we    = cmd.take_load && (32'(tri_slot) < MAX_TRIANGLES)
		&& (word_select < 4'(WORDS_PER_TRI));
	assign ram_waddr = AW'(32'(tri_slot) * WORDS_PER_TRI + 32'(word_select));
	assign ram_raddr = AW'(32'(slot_q) * WORDS_PER_TRI + 32'(wcnt_q));

	rthac_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (word_value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// per-axis / per-edge operand selection
	always_comb begin
		case (kcnt_q)
			2'd0: begin
				n_sel = w_q[W_NRM];     c_sel = w_q[W_PNT];
				e_sel = ex_q;           d_sel = dx_q;
				vxa = w_q[W_VTX];       vya = w_q[W_VTX+1];
				vxb = w_q[W_VTX+2];     vyb = w_q[W_VTX+3];
			end
			2'd1: begin
				n_sel = w_q[W_NRM+1];   c_sel = w_q[W_PNT+1];
				e_sel = ey_q;           d_sel = dy_q;
				vxa = w_q[W_VTX+2];     vya = w_q[W_VTX+3];
				vxb = w_q[W_VTX+4];     vyb = w_q[W_VTX+5];
			end
			default: begin
				n_sel = w_q[W_NRM+2];   c_sel = w_q[W_PNT+2];
				e_sel = ez_q;           d_sel = dz_q;
				vxa = w_q[W_VTX+4];     vya = w_q[W_VTX+5];
				vxb = w_q[W_VTX];       vyb = w_q[W_VTX+1];
			end
		endcase
	end

	assign ex33 = 33'(vxa) - 33'(vxb);
	assign ey33 = 33'(vya) - 33'(vyb);
	assign qx33 = 33'(px_q) - 33'(vxb);
	assign qy33 = 33'(py_q) - 33'(vyb);

	always_comb begin
		if (kcnt_q == 2'd0) begin
			g_s = $signed({1'b0, col_q}) - $signed({1'b0, half});
		end else begin
			g_s = $signed({1'b0, half}) - $signed({1'b0, row_q});
		end
	end

	assign w_sel   = sat32(SAT_W'(c_sel) - SAT_W'(e_sel));
	assign dmag    = d_sel[31] ? 32'(-d_sel) : 32'(d_sel);
	assign num_abs = num_q[ACC_W-1] ? -num_q : num_q;
	assign den_abs = den_q[ACC_W-1] ? -den_q : den_q;
	assign nmag    = (2*HW)'($unsigned(num_abs));
	assign pmag    = prod_q[65] ? $unsigned(-prod_q) : $unsigned(prod_q);

	// shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_GMUL: begin
				mul_a = 33'(g_s);
				mul_b = $signed({18'd0, ext_q});
			end
			OP_DMUL: begin
				mul_a = 33'(n_sel);
				mul_b = 33'(d_sel);
			end
			OP_NMUL: begin
				mul_a = 33'(n_sel);
				mul_b = 33'(w_sel);
			end
			OP_QLO: begin
				mul_a = $signed({1'b0, dmag});
				mul_b = $signed(33'(nmag[HW-1:0]));
			end
			OP_QHI: begin
				mul_a = $signed({1'b0, dmag});
				mul_b = $signed(33'(nmag[2*HW-1:HW]));
			end
			OP_CMUL1: begin
				mul_a = ex33;
				mul_b = qy33;
			end
			OP_CMUL2: begin
				mul_a = ey33;
				mul_b = qx33;
			end
			default: begin
			end
		endcase
	end

	// divider
	always_comb begin
		div_start = 1'b0;
		div_dvd   = DVD_W'(pix_q);
		div_dvs   = NM_W'(res_eff);
		case (cmd.op)
			OP_PDIV: begin
				div_start = 1'b1;
			end
			OP_GDIV: begin
				div_start = 1'b1;
				div_dvd   = DVD_W'(pmag) << FRAC_BITS;
			end
			OP_QDIV: begin
				div_start = 1'b1;
				div_dvd   = dvd_q + (DVD_W'($unsigned(prod_q)) << HW);
				div_dvs   = NM_W'($unsigned(den_abs));
			end
			default: begin
			end
		endcase
	end

	rthac_div #(.N(DVD_W), .M(NM_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	// truncated signed quotient, clamped
	assign q_s = neg_q ? -$signed({1'b0, div_quot}) : $signed({1'b0, div_quot});
	assign q32 = sat32(SAT_W'(q_s));

	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ex_q        <= '0;
			ey_q        <= '0;
			ez_q        <= '0;
			res_q       <= 9'd64;
			ext_q       <= 15'd64;
			tcnt_q      <= '0;
			out_valid_q <= 1'b0;
			rd_vld_q    <= 1'b0;
			kcnt_q      <= '0;
			wcnt_q      <= '0;
			slot_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_EMIT_X:    ex_q   <= cfg_data;
					CFG_EMIT_Y:    ey_q   <= cfg_data;
					CFG_EMIT_Z:    ez_q   <= cfg_data;
					CFG_IMG_RES:   res_q  <= cfg_data[8:0];
					CFG_DET_EXT:   ext_q  <= cfg_data[14:0];
					CFG_TRI_COUNT: tcnt_q <= cfg_data[8:0];
					default: begin
					end
				endcase
			end
			if (cmd.op == OP_DONE) begin
				out_valid_q <= 1'b1;
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
			rd_vld_q <= (cmd.op == OP_FETCH);
			if (cmd.take_cast) begin
				kcnt_q <= '0;
				slot_q <= '0;
			end
			case (cmd.op)
				OP_GEND, OP_QEND: kcnt_q <= (kcnt_q == 2'd1) ? 2'd0 : kcnt_q + 2'd1;
				OP_DACC, OP_NACC, OP_CCMP: kcnt_q <= (kcnt_q == 2'd2) ? 2'd0 : kcnt_q + 2'd1;
				OP_TSTART: begin
					kcnt_q <= '0;
					wcnt_q <= '0;
				end
				OP_FETCH: wcnt_q <= wcnt_q + 4'd1;
				OP_NEXT:  slot_q <= slot_q + 1'b1;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_q <= wcnt_q;
		if (rd_vld_q) begin
			w_q[rd_idx_q] <= $signed(ram_rdata);
		end
		if (cmd.take_cast) begin
			pix_q  <= pixel_number;
			sum_q  <= '0;
			hits_q <= '0;
			dz_q   <= sat32(-SAT_W'(ez_q));
		end
		case (cmd.op)
			OP_GMUL, OP_DMUL, OP_NMUL, OP_QLO, OP_CMUL1: prod_q <= mul_a * mul_b;
			OP_PEND: begin
				col_q <= RW'(div_rem);
				row_q <= RW'(div_quot);
			end
			OP_GDIV: neg_q <= prod_q[65];
			OP_GEND: begin
				if (kcnt_q == 2'd0) begin
					dx_q <= sat32(SAT_W'(q32) - SAT_W'(ex_q));
				end else begin
					dy_q <= sat32(SAT_W'(q32) - SAT_W'(ey_q));
				end
			end
			OP_TSTART: begin
				den_q <= '0;
				num_q <= '0;
			end
			OP_DACC: den_q <= den_q + ACC_W'(prod_q >>> FRAC_BITS);
			OP_NACC: num_q <= num_q + ACC_W'(prod_q >>> FRAC_BITS);
			OP_QHI: begin
				dvd_q  <= DVD_W'($unsigned(prod_q));
				prod_q <= mul_a * mul_b;
			end
			OP_QDIV: neg_q <= d_sel[31] ^ num_q[ACC_W-1] ^ den_q[ACC_W-1];
			OP_QEND: begin
				if (kcnt_q == 2'd0) begin
					px_q <= sat32(SAT_W'(ex_q) + SAT_W'(q32));
				end else begin
					py_q <= sat32(SAT_W'(ey_q) + SAT_W'(q32));
				end
			end
			OP_CMUL2: begin
				cp_q   <= prod_q;
				prod_q <= mul_a * mul_b;
			end
			OP_CCMP: begin
				pos_q <= ((kcnt_q == 2'd0) ? 1'b1 : pos_q) & (cp_q > prod_q);
				ng_q  <= ((kcnt_q == 2'd0) ? 1'b1 : ng_q) & (cp_q < prod_q);
			end
			OP_HIT: begin
				if (pos_q || ng_q) begin
					sum_q  <= sum_q + SUM_W'(w_q[W_COLOR]);
					hits_q <= hits_q + 1'b1;
				end
			end
			OP_DONE: begin
				pixel_out_q <= pix_q;
				color_sum_q <= sat32(SAT_W'(sum_q));
				hit_total_q <= (32'(hits_q) > 511) ? 9'd511 : 9'(hits_q);
			end
			default: begin
			end
		endcase
	end

	assign stat.pix_oor    = 32'(pix_q) >= 32'(res_eff) * 32'(res_eff);
	assign stat.div_busy   = div_busy;
	assign stat.fetch_last = (wcnt_q == 4'(WORDS_PER_TRI - 1));
	assign stat.dy_zero    = (dy_q == '0);
	assign stat.den_zero   = (den_q == '0);
	assign stat.slot_done  = (slot_q >= tcnt_eff);
	assign stat.kcnt       = kcnt_q;
	assign stat.out_free   = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign pixel_out = pixel_out_q;
	assign color_sum = color_sum_q;
	assign hit_total = hit_total_q;

endmodule

/* hw/rtl/rthac_ctrl.sv */
// Controller state machine sequencing casts and the per-triangle test.
module rthac_ctrl import rthac_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     req_type,
	input  dp_stat_t stat,
	output logic     in_stall,
	output dp_cmd_t  cmd
);

	ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:   if (in_valid && req_type) state_d = S_PDIV;
			S_PDIV:   state_d = stat.pix_oor ? S_IDLE : S_PWAIT;
			S_PWAIT:  if (!stat.div_busy) state_d = S_PEND;
			S_PEND:   state_d = S_GMUL;
			S_GMUL:   state_d = S_GDIV;
			S_GDIV:   state_d = S_GWAIT;
			S_GWAIT:  if (!stat.div_busy) state_d = S_GEND;
			S_GEND:   state_d = (stat.kcnt == 2'd1) ? S_TSTART : S_GMUL;
			S_TSTART: state_d = stat.slot_done ? S_FIN : S_FETCH;
			S_FETCH:  if (stat.fetch_last) state_d = S_FWAIT;
			S_FWAIT:  state_d = stat.dy_zero ? S_NEXT : S_DMUL;
			S_DMUL:   state_d = S_DACC;
			S_DACC:   state_d = (stat.kcnt == 2'd2) ? S_NMUL : S_DMUL;
			S_NMUL:   state_d = S_NACC;
			S_NACC: begin
				if (stat.kcnt == 2'd2) begin
					state_d = stat.den_zero ? S_NEXT : S_QLO;
				end else begin
					state_d = S_NMUL;
				end
			end
			S_QLO:    state_d = S_QHI;
			S_QHI:    state_d = S_QDIV;
			S_QDIV:   state_d = S_QWAIT;
			S_QWAIT:  if (!stat.div_busy) state_d = S_QEND;
			S_QEND:   state_d = (stat.kcnt == 2'd1) ? S_CMUL1 : S_QLO;
			S_CMUL1:  state_d = S_CMUL2;
			S_CMUL2:  state_d = S_CCMP;
			S_CCMP:   state_d = (stat.kcnt == 2'd2) ? S_HIT : S_CMUL1;
			S_HIT:    state_d = S_NEXT;
			S_NEXT:   state_d = S_TSTART;
			S_FIN:    if (stat.out_free) state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = (state_q != S_IDLE);
		cmd.op        = OP_NONE;
		cmd.take_load = 1'b0;
		cmd.take_cast = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd.take_load = in_valid && !req_type;
				cmd.take_cast = in_valid && req_type;
			end
			S_PDIV:   cmd.op = stat.pix_oor ? OP_NONE : OP_PDIV;
			S_PEND:   cmd.op = OP_PEND;
			S_GMUL:   cmd.op = OP_GMUL;
			S_GDIV:   cmd.op = OP_GDIV;
			S_GEND:   cmd.op = OP_GEND;
			S_TSTART: cmd.op = stat.slot_done ? OP_NONE : OP_TSTART;
			S_FETCH:  cmd.op = OP_FETCH;
			S_DMUL:   cmd.op = OP_DMUL;
			S_DACC:   cmd.op = OP_DACC;
			S_NMUL:   cmd.op = OP_NMUL;
			S_NACC:   cmd.op = OP_NACC;
			S_QLO:    cmd.op = OP_QLO;
			S_QHI:    cmd.op = OP_QHI;
			S_QDIV:   cmd.op = OP_QDIV;
			S_QEND:   cmd.op = OP_QEND;
			S_CMUL1:  cmd.op = OP_CMUL1;
			S_CMUL2:  cmd.op = OP_CMUL2;
			S_CCMP:   cmd.op = OP_CCMP;
			S_HIT:    cmd.op = OP_HIT;
			S_NEXT:   cmd.op = OP_NEXT;
			S_FIN:    cmd.op = stat.out_free ? OP_DONE : OP_NONE;
			default:  cmd.op = OP_NONE;
		endcase
	end

endmodule

/* hw/rtl/ray_triangle_hit_accumulate_core.sv */
// Top level of the ray/triangle hit accumulator.
// Load transactions (req_type 0) write one word of the triangle table without stalling the
// input. A cast transaction (req_type 1) traces the ray from the emitter through one
// detector pixel against the first triangle_count table entries and returns one result with
// the clamped color sum and hit count; a pixel outside the detector returns nothing. A cast
// holds the input until it finishes. Its length is set by the serial divider, which yields
// one quotient bit per cycle over its width D = 98 - FRAC_BITS rounded up to even, and by
// the single shared 33x33 multiplier; triangles that miss early skip the divides. The finished
// result sits in an output register so the next transaction can be accepted while it waits.
module ray_triangle_hit_accumulate_core import rthac_pkg::*; #(
	parameter int MAX_TRIANGLES  = 256,
	parameter int MAX_RESOLUTION = 256,
	parameter int FRAC_BITS      = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [7:0]         tri_slot,
	input  logic [3:0]         word_select,
	input  logic signed [31:0] word_value,
	input  logic [15:0]        pixel_number,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        pixel_out,
	output logic signed [31:0] color_sum,
	output logic [8:0]         hit_total
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rthac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.req_type (req_type),
		.stat     (stat),
		.in_stall (in_stall),
		.cmd      (cmd)
	);

	rthac_dp #(
		.MAX_TRIANGLES  (MAX_TRIANGLES),
		.MAX_RESOLUTION (MAX_RESOLUTION),
		.FRAC_BITS      (FRAC_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.tri_slot     (tri_slot),
		.word_select  (word_select),
		.word_value   (word_value),
		.pixel_number (pixel_number),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.pixel_out    (pixel_out),
		.color_sum    (color_sum),
		.hit_total    (hit_total)
	);

	a_cast_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && req_type) |=> in_stall)
		else $error("cast transaction did not stall the input");

	a_load_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall && !req_type) |=> !in_stall)
		else $error("load transaction stalled the input");

	a_no_hit_no_color: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && hit_total == 9'd0) |-> (color_sum == 32'sd0))
		else $error("color sum without any hit");

	a_result_from_cast: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared while no cast was in progress");

endmodule

/* sim/tb.sv */
// Testbench for ray_triangle_hit_accumulate_core: triangle loads, pixel casts, checked results.
`timescale 1ns / 1ps
module tb;
	import rthac_pkg::*;

	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_CAST = 1'b1;
	localparam int MAX_TRI = 256;
	localparam int MAX_RES = 256;
	localparam int BIG_TRI = 40;
	localparam int U = 65536;
	localparam longint CYCLE_LIMIT = 6000000;

	typedef struct {
		logic [15:0]        pix;
		logic signed [31:0] sum;
		logic [8:0]         hits;
	} hit_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic [7:0] tri_slot = '0;
	logic [3:0] word_select = '0;
	logic signed [31:0] word_value = '0;
	logic [15:0] pixel_number = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [15:0] pixel_out;
	logic signed [31:0] color_sum;
	logic [8:0] hit_total;

	ray_triangle_hit_accumulate_core dut (.*);

	always #1 clk = ~clk;

	// shadow copy of the block's state
	logic [31:0] tri_mem [0:MAX_TRI*WORDS_PER_TRI-1];
	logic signed [31:0] emx = 0, emy = 0, emz = 0;
	logic [8:0] img_res = 9'd64;
	logic [14:0] det_ext = 15'd64;
	logic [8:0] tri_cnt = 9'd0;

	hit_result_t pixel_q[$];
	int errors = 0;
	int items_sent = 0;
	int casts_sent = 0;
	int results_seen = 0;
	int hit_results = 0;
	bit tx_steady = 0;
	bit rx_steady = 0;
	int rx_hold_req = 0;
	longint cycles = 0;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycles, pixel_q.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic signed [31:0] clamp32(input logic signed [127:0] v);
		if (v > 128'sd2147483647) return 32'sh7fff_ffff;
		if (v < -128'sd2147483648) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic signed [31:0] tri_word(input int s, input int k);
		return tri_mem[s*WORDS_PER_TRI+k];
	endfunction

	function automatic int eff_count();
		return (tri_cnt > MAX_TRI) ? MAX_TRI : int'(tri_cnt);
	endfunction

	function automatic bit ray_hits(input int s, input logic signed [31:0] dx,
			input logic signed [31:0] dy, input logic signed [31:0] dz);
		logic signed [31:0] e[3], d[3], vx[3], vy[3];
		logic signed [31:0] n, w;
		logic signed [127:0] t, den, num, q, px, py, cx, cy, rx, ry, cr;
		int sg[3];
		int a, b;
		e[0] = emx; e[1] = emy; e[2] = emz;
		d[0] = dx; d[1] = dy; d[2] = dz;
		if (dy == 0) return 0;
		den = 0;
		num = 0;
		for (int k = 0; k < 3; k++) begin
			n = tri_word(s, W_NRM + k);
			t = tri_word(s, W_PNT + k);
			t = t - e[k];
			w = clamp32(t);
			t = n * d[k];
			den = den + (t >>> 16);
			t = n * w;
			num = num + (t >>> 16);
		end
		if (den == 0) return 0;
		t = dx * num;
		q = clamp32(t / den);
		t = q + e[0];
		px = clamp32(t);
		t = dy * num;
		q = clamp32(t / den);
		t = q + e[1];
		py = clamp32(t);
		for (int k = 0; k < 3; k++) begin
			vx[k] = tri_word(s, W_VTX + 2*k);
			vy[k] = tri_word(s, W_VTX + 2*k + 1);
		end
		for (int k = 0; k < 3; k++) begin
			a = k;
			b = (k + 1) % 3;
			cx = vx[a] - vx[b];
			cy = vy[a] - vy[b];
			rx = px - vx[b];
			ry = py - vy[b];
			cr = cx*ry - cy*rx;
			sg[k] = (cr > 0) ? 1 : ((cr < 0) ? -1 : 0);
		end
		return (sg[0] > 0 && sg[1] > 0 && sg[2] > 0) || (sg[0] < 0 && sg[1] < 0 && sg[2] < 0);
	endfunction

	function automatic bit trace_pixel(input logic [15:0] pix, output hit_result_t r);
		longint res, p, half, gx, gy, scale, sum, hits;
		logic signed [127:0] t;
		logic signed [31:0] dx, dy, dz;
		res = img_res;
		if (res == 0) res = 1;
		if (res > MAX_RES) res = MAX_RES;
		p = pix;
		if (p >= res*res) return 0;
		half = res / 2;
		gx = p % res - half;
		gy = half - p / res;
		scale = longint'(det_ext) * U;
		t = clamp32(gx*scale/res);
		t = t - emx;
		dx = clamp32(t);
		t = clamp32(gy*scale/res);
		t = t - emy;
		dy = clamp32(t);
		t = 0;
		t = t - emz;
		dz = clamp32(t);
		sum = 0;
		hits = 0;
		for (int s = 0; s < eff_count(); s++) begin
			if (ray_hits(s, dx, dy, dz)) begin
				sum += longint'(tri_word(s, W_COLOR));
				hits++;
			end
		end
		r.pix = pix;
		r.sum = clamp32(sum);
		r.hits = (hits > 511) ? 9'd511 : hits[8:0];
		return 1;
	endfunction

	function automatic int pick_gap(input bit steady);
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	// result checker and output stall generator
	always @(posedge clk) begin
		static int stall_left = 0;
		hit_result_t want;
		if (out_valid && !out_stall) begin
			results_seen++;
			if (pixel_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: unexpected result pixel %0d sum %0d hits %0d",
						pixel_out, color_sum, hit_total);
			end else begin
				want = pixel_q.pop_front();
				if (hit_total != 0) hit_results++;
				if (pixel_out !== want.pix || color_sum !== want.sum ||
						hit_total !== want.hits) begin
					errors++;
					if (errors <= 10)
						$display("ERROR: pixel exp %0d got %0d, sum exp %0d got %0d, hits exp %0d got %0d",
							want.pix, pixel_out, want.sum, color_sum, want.hits, hit_total);
				end
			end
		end
		if (rx_hold_req > 0) begin
			stall_left = rx_hold_req;
			rx_hold_req = 0;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
			out_stall <= 1'b1;
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// called just after a rising edge; leaves in_valid high for a back-to-back follow-up
	task automatic send_item(input logic rt, input logic [7:0] slot, input logic [3:0] ws,
			input logic [31:0] val, input logic [15:0] pix);
		int gap;
		hit_result_t r;
		gap = pick_gap(tx_steady);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		tri_slot <= slot;
		word_select <= ws;
		word_value <= val;
		pixel_number <= pix;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
		if (rt == REQ_LOAD) begin
			if (ws < WORDS_PER_TRI) tri_mem[slot*WORDS_PER_TRI+ws] = val;
		end else begin
			casts_sent++;
			if (trace_pixel(pix, r)) pixel_q.insert(pixel_q.size(), r);
		end
	endtask

	task automatic load_word(input int slot, input int ws, input logic [31:0] val);
		send_item(REQ_LOAD, slot[7:0], ws[3:0], val, 16'($urandom));
	endtask

	task automatic cast(input logic [15:0] pix);
		send_item(REQ_CAST, 8'($urandom), 4'($urandom), $urandom, pix);
	endtask

	// block is idle once all results are in; the extra wait grows with the effective triangle count
	task automatic drain();
		in_valid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (300 + 200*eff_count()) @(posedge clk);
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_EMIT_X:    emx = val;
			CFG_EMIT_Y:    emy = val;
			CFG_EMIT_Z:    emz = val;
			CFG_IMG_RES:   img_res = val[8:0];
			CFG_DET_EXT:   det_ext = val[14:0];
			CFG_TRI_COUNT: tri_cnt = val[8:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic set_scene(input logic [31:0] ex, input logic [31:0] ey, input logic [31:0] ez,
			input int res, input int ext, input int cnt);
		set_reg(CFG_EMIT_X, ex);
		set_reg(CFG_EMIT_Y, ey);
		set_reg(CFG_EMIT_Z, ez);
		set_reg(CFG_IMG_RES, res);
		set_reg(CFG_DET_EXT, ext);
		set_reg(CFG_TRI_COUNT, cnt);
	endtask

	function automatic logic [31:0] rand_coord(input longint span);
		return 32'(longint'($urandom) % (2*span + 1) - span);
	endfunction

	function automatic logic [31:0] rand_color();
		case ($urandom_range(0, 9))
			0: return 32'h7fff_ffff;
			1: return 32'h8000_0000;
			2: return $urandom;
			default: return 32'($signed($urandom_range(0, 2000)) - 1000);
		endcase
	endfunction

	// mode 0: plane parallel to detector between it and the emitter, 1: tilted, 2: random words
	task automatic load_triangle(input int slot, input int mode);
		logic [31:0] w[WORDS_PER_TRI];
		longint span;
		span = longint'(det_ext) * (U/2) + U;
		for (int k = 0; k < WORDS_PER_TRI; k++) w[k] = $urandom;
		if (mode != 2) begin
			if (mode == 0) begin
				w[0] = 0;
				w[1] = 0;
				w[2] = $urandom_range(1, 4) * U;
			end else begin
				for (int k = 0; k < 3; k++) w[k] = $urandom_range(0, 6*U) - 3*U;
			end
			w[3] = rand_coord(span);
			w[4] = rand_coord(span);
			w[5] = (emz > 0) ? 32'(longint'($urandom) % longint'(emz)) : 0;
			for (int k = W_VTX; k < W_COLOR; k++) w[k] = rand_coord(span);
			w[W_COLOR] = rand_color();
		end
		for (int k = 0; k < WORDS_PER_TRI; k++) load_word(slot, k, w[k]);
	endtask

	task automatic load_fixed(input int slot, input int nz, input int h, input int x1,
			input int y1, input int x2, input int y2, input int x3, input int y3,
			input logic [31:0] color);
		load_word(slot, 0, 0);
		load_word(slot, 1, 0);
		load_word(slot, 2, nz*U);
		load_word(slot, 3, 0);
		load_word(slot, 4, 0);
		load_word(slot, 5, h*U);
		load_word(slot, 6, x1*U);
		load_word(slot, 7, y1*U);
		load_word(slot, 8, x2*U);
		load_word(slot, 9, y2*U);
		load_word(slot, 10, x3*U);
		load_word(slot, 11, y3*U);
		load_word(slot, 12, color);
	endtask

	function automatic logic [15:0] rand_pixel();
		int res;
		res = (img_res == 0) ? 1 : ((img_res > MAX_RES) ? MAX_RES : int'(img_res));
		if ($urandom_range(0, 99) < 88) return 16'($urandom_range(0, res*res - 1));
		return 16'($urandom);
	endfunction

	// emitter 16 units above a 4x4 detector of 4 units; pixel at grid point (col-2, 2-row)
	task automatic test_directed();
		tx_steady = 0;
		rx_steady = 0;
		set_scene(0, 0, 16*U, 4, 4, 0);
		load_fixed(0, 1, 8, -100, -100, 100, -100, 0, 100, 32'h7fff_ffff);
		load_fixed(1, 1, 8, -100, -100, 100, -100, 0, 100, 32'h7fff_ffff);
		load_fixed(2, 0, 8, -100, -100, 100, -100, 0, 100, 5);  // zero normal
		load_fixed(3, 1, 8, 3, 3, 3, 3, 3, 3, 7);                // collapsed to a point
		load_fixed(4, 1, 8, -1, 1, 5, 1, 0, -5, 9);              // pixel 0 lands on a vertex
		cast(0);
		drain();
		set_reg(CFG_TRI_COUNT, 5);
		cast(0);
		cast(5);
		cast(10);    // ray has no y component
		cast(15);
		cast(16);    // outside the detector
		cast(16'hffff);
		load_word(0, 13, 32'h1234_5678);
		load_word(0, 14, 32'h1234_5678);
		load_word(0, 15, 32'h1234_5678);
		load_word(0, W_COLOR, 32'h8000_0000);
		load_word(1, W_COLOR, 32'h8000_0000);
		cast(6);
		load_word(255, W_COLOR, 1);
		cast(3);
		drain();
		set_reg(CFG_TRI_COUNT, 0);
		cast(12);
		drain();
	endtask

	task automatic test_large_table();
		tx_steady = 1;
		set_scene($urandom_range(0, 4*U) - 2*U, $urandom_range(0, 4*U) - 2*U, 40*U, 16, 48, 0);
		for (int s = 0; s < BIG_TRI; s++) load_triangle(s, 0);
		drain();
		set_reg(CFG_TRI_COUNT, BIG_TRI);
		tx_steady = 0;
		cast(16'd136);
		cast(rand_pixel());
		drain();
		set_reg(CFG_IMG_RES, MAX_RES);
		cast(16'hffff);
		drain();
	endtask

	task automatic test_extremes();
		set_scene(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, MAX_RES, 32767, 8);
		for (int i = 0; i < 10; i++) cast(16'($urandom));
		drain();
		set_scene(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1, 1, 8);
		cast(0);
		cast(1);
		drain();
	endtask

	task automatic run_scene(input int n_casts, input bit pressure);
		int cnt, mode;
		mode = $urandom_range(0, 9);
		mode = (mode < 6) ? 0 : ((mode < 9) ? 1 : 2);
		cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
		if (mode == 2)
			set_scene($urandom, $urandom, $urandom, $urandom_range(1, MAX_RES),
				$urandom_range(1, 32767), 0);
		else
			set_scene($urandom_range(0, 8*U) - 4*U, $urandom_range(0, 8*U) - 4*U,
				$urandom_range(1, 200)*U + $urandom_range(0, U-1),
				($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_RES) : $urandom_range(1, 32),
				($urandom_range(0, 9) == 0) ? 32767 : $urandom_range(1, 200), 0);
		tx_steady = ($urandom_range(0, 3) == 0);
		rx_steady = ($urandom_range(0, 3) == 0);
		for (int s = 0; s < cnt; s++) load_triangle(s, ($urandom_range(0, 4) == 0) ? 2 : mode);
		drain();
		set_reg(CFG_TRI_COUNT, cnt);
		if (pressure) begin
			tx_steady = 1;
			rx_hold_req = 4000;
		end
		for (int i = 0; i < n_casts; i++) begin
			if ($urandom_range(0, 9) == 0)
				load_word($urandom_range(0, 255), $urandom_range(0, 15), $urandom);
			cast(rand_pixel());
		end
		drain();
	endtask

	task automatic test_backpressure();
		run_scene(12, 1);
	endtask

	task automatic test_random();
		while (items_sent < 1100) run_scene($urandom_range(15, 35), 0);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_large_table();
		test_extremes();
		test_backpressure();
		test_random();
		drain();
		$display("Sent %0d transactions (%0d casts); checked %0d pixel results, %0d with hits.",
			items_sent, casts_sent, results_seen, hit_results);
		$display("Covered a 40-entry table, register extremes and output backpressure.");
		if (errors == 0 && pixel_q.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d mismatches", errors);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

/* files.f */
hw/rtl/rthac_pkg.sv
hw/rtl/rthac_ram.sv
hw/rtl/rthac_div.sv
hw/rtl/rthac_dp.sv
hw/rtl/rthac_ctrl.sv
hw/rtl/ray_triangle_hit_accumulate_core.sv
sim/tb.sv
